// ===== design/sha1c_pkg.sv =====
// Shared constants and round functions of the SHA-1 block compression unit.
package sha1c_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUND_COUNT = 80;
   localparam int ADDR_W      = $clog2(BLOCK_WORDS);
   localparam int ROUND_W     = $clog2(ROUND_COUNT);

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_WORD  = 1'b1;

   localparam logic [WORD_W-1:0] K_CH  = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_P1  = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_MAJ = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_P3  = 32'hca62c1d6;

   typedef logic [WORD_W-1:0] word_type;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = word_type'((v << n) | (v >> (WORD_W - n)));
   endfunction

   // Round function and constant, chosen by the round's group of twenty.
   function automatic word_type round_f(input logic [ROUND_W-1:0] t,
                                        input word_type b, input word_type c,
                                        input word_type d);
      if (t < ROUND_W'(20))
         round_f = (b & c) | (~b & d);
      else if (t < ROUND_W'(40))
         round_f = b ^ c ^ d;
      else if (t < ROUND_W'(60))
         round_f = (b & c) | (b & d) | (c & d);
      else
         round_f = b ^ c ^ d;
   endfunction

   function automatic word_type round_k(input logic [ROUND_W-1:0] t);
      if (t < ROUND_W'(20))
         round_k = K_CH;
      else if (t < ROUND_W'(40))
         round_k = K_P1;
      else if (t < ROUND_W'(60))
         round_k = K_MAJ;
      else
         round_k = K_P3;
   endfunction

endpackage

// ===== design/sha1c_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module sha1c_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== design/sha1_block_compression_unit.sv =====
// SHA-1 block compression unit: word collection, schedule RAM and round datapath.
// Flow: after a block's sixteenth word beat come the schedule read-ahead (ST_PREP),
// the 80 rounds (ST_ROUND) and one chaining add (ST_FINAL), which presents the result.
// No new word is taken while a block is being compressed; the round loop runs one round per
// cycle, fed by four schedule reads from two mirrored RAMs.
// Reset: chaining value and word count go to zero, no result pending; the schedule
// RAM is not cleared, as every entry is rewritten before a compression reads it.
module sha1_block_compression_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_message_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_h0,
   output logic [31:0] rsp_hash_h1,
   output logic [31:0] rsp_hash_h2,
   output logic [31:0] rsp_hash_h3,
   output logic [31:0] rsp_hash_h4
);

   localparam int AW = sha1c_pkg::ADDR_W;
   localparam int RW = sha1c_pkg::ROUND_W;

   // Sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PREP  = 2'd1;  // first schedule read in flight
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;  // add into chaining value

   logic [1:0]    state_ff, state_in;
   logic [RW-1:0] round_ff, round_in;
   logic [AW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   sha1c_pkg::word_type chain_ff [5];
   sha1c_pkg::word_type chain_in [5];
   sha1c_pkg::word_type rsp_ff   [5];
   sha1c_pkg::word_type rsp_in   [5];
   sha1c_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1c_pkg::word_type a_in, b_in, c_in, d_in, e_in;

   // Schedule RAM signals (two mirrored copies give four read ports)
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   sha1c_pkg::word_type wr_data;
   logic [AW-1:0]       rd_addr_a, rd_addr_b, rd_addr_c, rd_addr_d;
   sha1c_pkg::word_type rd_a, rd_b, rd_c, rd_d;

   logic                req_beat, rsp_beat, word_beat, last_word;
   logic [RW-1:0]       next_round;
   logic [AW-1:0]       nr_lo;
   sha1c_pkg::word_type w_cur, t_sum;

   sha1c_ram #(.WIDTH(sha1c_pkg::WORD_W), .DEPTH(sha1c_pkg::BLOCK_WORDS)) u_ram0 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   sha1c_ram #(.WIDTH(sha1c_pkg::WORD_W), .DEPTH(sha1c_pkg::BLOCK_WORDS)) u_ram1 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_c),
      .rd_data_a (rd_c),
      .rd_addr_b (rd_addr_d),
      .rd_data_b (rd_d)
   );

   // At the block-ending position any request, word or clear, waits while the previous digest is still untaken.
   assign req_ready = (state_ff == ST_IDLE) &&
                      !(rsp_valid_ff && (count_ff == AW'(sha1c_pkg::BLOCK_WORDS - 1)));
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid_ff && rsp_ready;
   assign word_beat = req_beat && (req_opcode == sha1c_pkg::OP_WORD);
   assign last_word = word_beat && (count_ff == AW'(sha1c_pkg::BLOCK_WORDS - 1));

   // Read-ahead for the next round: W[t-3], W[t-8], W[t-14], W[t-16], all mod 16.
   // During rounds 0..15 port a simply fetches the collected word.
   assign next_round = (state_ff == ST_ROUND) ? RW'(round_ff + RW'(1)) : '0;
   assign nr_lo      = next_round[AW-1:0];
   assign rd_addr_a  = (next_round < RW'(sha1c_pkg::BLOCK_WORDS)) ? nr_lo
                                                                  : AW'(nr_lo + AW'(13));
   assign rd_addr_b  = AW'(nr_lo + AW'(8));
   assign rd_addr_c  = AW'(nr_lo + AW'(2));
   assign rd_addr_d  = nr_lo;

   // Current schedule word; expanded words are written back over W[t-16].
   always_comb begin
      if (round_ff < RW'(sha1c_pkg::BLOCK_WORDS))
         w_cur = rd_a;
      else
         w_cur = sha1c_pkg::rotl(rd_a ^ rd_b ^ rd_c ^ rd_d, 1);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff;
      wr_data = req_message_word;
      if (word_beat) begin
         wr_en = 1'b1;
      end else if ((state_ff == ST_ROUND) &&
                   (round_ff >= RW'(sha1c_pkg::BLOCK_WORDS))) begin
         wr_en   = 1'b1;
         wr_addr = round_ff[AW-1:0];
         wr_data = w_cur;
      end
   end

   assign t_sum = sha1c_pkg::word_type'(sha1c_pkg::rotl(a_ff, 5)
                  + sha1c_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                  + e_ff + w_cur + sha1c_pkg::round_k(round_ff));

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      chain_in     = chain_ff;
      rsp_in       = rsp_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;

      if (rsp_beat)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_opcode == sha1c_pkg::OP_CLEAR) begin
                  count_in = '0;
                  for (int i = 0; i < 5; i++)
                     chain_in[i] = '0;
               end else begin
                  count_in = AW'(count_ff + AW'(1));
                  if (last_word)
                     state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            e_in     = chain_ff[4];
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            a_in     = t_sum;
            b_in     = a_ff;
            c_in     = sha1c_pkg::rotl(b_ff, 30);
            d_in     = c_ff;
            e_in     = d_ff;
            round_in = next_round;
            if (round_ff == RW'(sha1c_pkg::ROUND_COUNT - 1))
               state_in = ST_FINAL;
         end
         ST_FINAL: begin
            chain_in[0] = sha1c_pkg::word_type'(chain_ff[0] + a_ff);
            chain_in[1] = sha1c_pkg::word_type'(chain_ff[1] + b_ff);
            chain_in[2] = sha1c_pkg::word_type'(chain_ff[2] + c_ff);
            chain_in[3] = sha1c_pkg::word_type'(chain_ff[3] + d_ff);
            chain_in[4] = sha1c_pkg::word_type'(chain_ff[4] + e_ff);
            rsp_in       = chain_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++)
            chain_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Working variables and digest hold, no reset needed
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hash_h0 = rsp_ff[0];
   assign rsp_hash_h1 = rsp_ff[1];
   assign rsp_hash_h2 = rsp_ff[2];
   assign rsp_hash_h3 = rsp_ff[3];
   assign rsp_hash_h4 = rsp_ff[4];

endmodule

// ===== verif/sha1_block_compression_checker.sv =====
// Checker for the SHA-1 block compression unit: predicts each block's chaining value and compares.
`timescale 1ns / 1ps

module sha1_block_compression_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_message_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_hash_h0,
   input  logic [31:0] rsp_hash_h1,
   input  logic [31:0] rsp_hash_h2,
   input  logic [31:0] rsp_hash_h3,
   input  logic [31:0] rsp_hash_h4,
   output int          fail_count,
   output int          pending
);

   typedef logic [4:0][sha1c_pkg::WORD_W-1:0] hash_type;

   hash_type            chain_value;
   sha1c_pkg::word_type block_buf [sha1c_pkg::BLOCK_WORDS];
   logic [3:0]          word_pos;
   hash_type            hash_queue [$];
   int                  mismatch_count = 0;

   assign fail_count = mismatch_count;

   function automatic sha1c_pkg::word_type rol1(input sha1c_pkg::word_type v);
      return {v[30:0], v[31]};
   endfunction

   function automatic sha1c_pkg::word_type rol5(input sha1c_pkg::word_type v);
      return {v[26:0], v[31:27]};
   endfunction

   function automatic sha1c_pkg::word_type rol30(input sha1c_pkg::word_type v);
      return {v[1:0], v[31:2]};
   endfunction

   // 80-round compression of one block, added back into the chaining value
   function automatic hash_type sha1_compress(
      input hash_type cv,
      input sha1c_pkg::word_type blk [sha1c_pkg::BLOCK_WORDS]);
      sha1c_pkg::word_type w [sha1c_pkg::ROUND_COUNT];
      sha1c_pkg::word_type a, b, c, d, e, f, k, sum;
      hash_type            nx;
      int                  t;
      for (t = 0; t < sha1c_pkg::BLOCK_WORDS; t++)
         w[t] = blk[t];
      for (t = sha1c_pkg::BLOCK_WORDS; t < sha1c_pkg::ROUND_COUNT; t++)
         w[t] = rol1(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16]);
      a = cv[0];
      b = cv[1];
      c = cv[2];
      d = cv[3];
      e = cv[4];
      for (t = 0; t < sha1c_pkg::ROUND_COUNT; t++) begin
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = sha1c_pkg::K_CH;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1c_pkg::K_P1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1c_pkg::K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = sha1c_pkg::K_P3;
         end
         sum = rol5(a) + f + e + w[t] + k;
         e = d;
         d = c;
         c = rol30(b);
         b = a;
         a = sum;
      end
      nx[0] = cv[0] + a;
      nx[1] = cv[1] + b;
      nx[2] = cv[2] + c;
      nx[3] = cv[3] + d;
      nx[4] = cv[4] + e;
      return nx;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      hash_type got;
      hash_type want;
      int       i;
      if (reset) begin
         chain_value = '0;
         word_pos    = '0;
         hash_queue.delete();
      end else begin
         // result side first: a beat accepted now can never belong to a word taken now
         if (rsp_valid && rsp_ready) begin
            got[0] = rsp_hash_h0;
            got[1] = rsp_hash_h1;
            got[2] = rsp_hash_h2;
            got[3] = rsp_hash_h3;
            got[4] = rsp_hash_h4;
            if (hash_queue.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected, h0 %h", got[0]));
            end else begin
               want = hash_queue.pop_front();
               for (i = 0; i < 5; i++)
                  if (got[i] !== want[i])
                     report_mismatch($sformatf("hash_h%0d got %h want %h", i, got[i], want[i]));
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == sha1c_pkg::OP_CLEAR) begin
               chain_value = '0;
               word_pos    = '0;
            end else begin
               block_buf[word_pos] = req_message_word;
               word_pos = word_pos + 4'd1;
               if (word_pos == 4'd0) begin
                  chain_value = sha1_compress(chain_value, block_buf);
                  hash_queue.push_back(chain_value);
               end
            end
         end
      end
      pending <= hash_queue.size();
   end

endmodule

// ===== verif/tb_sha1_block_compression_unit.sv =====
// Testbench top for the SHA-1 block compression unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_sha1_block_compression_unit;

   // The cycle limit leaves ample margin over the slowest correct run of roughly 100 blocks.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1600;
   // Drain covers the wait from the last word to its result, the longest receiver stall and slack.
   localparam int DRAIN_CYCLES = 120;
   localparam int MAX_GAP      = 14;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_opcode       = sha1c_pkg::OP_CLEAR;
   logic [31:0] req_message_word = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_hash_h0, rsp_hash_h1, rsp_hash_h2, rsp_hash_h3, rsp_hash_h4;

   int fail_count;
   int pending;
   int items_sent  = 0;
   int cycle_count = 0;

   // Burst flags switch off the random gaps so back-to-back stretches also occur.
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   sha1_block_compression_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_message_word (req_message_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_h0      (rsp_hash_h0),
      .rsp_hash_h1      (rsp_hash_h1),
      .rsp_hash_h2      (rsp_hash_h2),
      .rsp_hash_h3      (rsp_hash_h3),
      .rsp_hash_h4      (rsp_hash_h4)
   );

   sha1_block_compression_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_message_word (req_message_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_h0      (rsp_hash_h0),
      .rsp_hash_h1      (rsp_hash_h1),
      .rsp_hash_h2      (rsp_hash_h2),
      .rsp_hash_h3      (rsp_hash_h3),
      .rsp_hash_h4      (rsp_hash_h4),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Word values skewed towards the corners: zero, all ones, single bits set or clear.
   function automatic logic [31:0] pick_word();
      logic [31:0] onehot;
      onehot = 32'h1 << $urandom_range(0, 31);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return onehot;
         3:       return ~onehot;
         default: return $urandom();
      endcase
   endfunction

   // One input beat. An optional idle gap first, then valid held with a stable payload
   // until the unit takes it. With no gap valid simply stays high into the next beat.
   task automatic send_item(input logic op, input logic [31:0] word);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_message_word <= word;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   task automatic send_block();
      int i;
      for (i = 0; i < sha1c_pkg::BLOCK_WORDS; i++)
         send_item(sha1c_pkg::OP_WORD, pick_word());
   endtask

   // Receiver: per result beat, a drawn stall with ready low, then ready high until taken.
   // Ready is only lowered when a stall is drawn, so a zero stall keeps it high throughout.
   initial begin : receiver
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0)
            recv_burst = ~recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int i;
      int n;
      int kind;
      logic [31:0] w;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: clear with a non-zero (ignored) word, then one block whose words
      // span zero, all ones and walking single bits; its last word wraps the count.
      send_item(sha1c_pkg::OP_CLEAR, 32'hffff_ffff);
      for (i = 0; i < sha1c_pkg::BLOCK_WORDS; i++) begin
         if (i == 0)
            w = '0;
         else if (i == 1)
            w = '1;
         else if (i[0])
            w = ~(32'h1 << (2 * i - 1));
         else
            w = 32'h1 << (2 * i - 1);
         send_item(sha1c_pkg::OP_WORD, w);
      end
      // Clear part way through a block, then a clear straight after a clear.
      send_item(sha1c_pkg::OP_WORD, 32'h8000_0000);
      send_item(sha1c_pkg::OP_WORD, 32'h0000_0001);
      send_item(sha1c_pkg::OP_WORD, 32'hdead_beef);
      send_item(sha1c_pkg::OP_CLEAR, 32'h0);
      send_item(sha1c_pkg::OP_CLEAR, 32'h1234_5678);

      // Random: mostly complete blocks with random content, some clears and
      // blocks broken off by a clear. Every sequence leaves the count at zero.
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0)
            send_burst = ~send_burst;
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            send_item(sha1c_pkg::OP_CLEAR, $urandom());
         end else if (kind <= 2) begin
            n = $urandom_range(1, sha1c_pkg::BLOCK_WORDS - 1);
            for (i = 0; i < n; i++)
               send_item(sha1c_pkg::OP_WORD, pick_word());
            send_item(sha1c_pkg::OP_CLEAR, $urandom());
         end else begin
            send_block();
         end
      end
      req_valid <= 1'b0;

      // Drain: pending is a registered copy of the queue size, so step before testing it.
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
